// ===== rtl/sdaf_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the formatter.
`timescale 1ns / 1ps

package sdaf_pkg;

    localparam int MAX_FIELD_WIDTH = 32;
    localparam int FIELD_W         = 6;
    localparam int CNT_W           = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int DIGITS          = 10;
    localparam int DIG_IDX_W       = $clog2(DIGITS);
    localparam int CHAR_W          = 6;
    localparam int VALUE_W         = 32;
    localparam int QUOT_W          = 29;

    localparam logic [FIELD_W-1:0]   WIDTH_RESET = FIELD_W'(8);
    localparam logic [VALUE_W-1:0]   RECIP_TEN   = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]    CH_BLANK    = CHAR_W'(32);
    localparam logic [CHAR_W-1:0]    CH_MINUS    = CHAR_W'(45);
    localparam logic [CHAR_W-1:0]    CH_ZERO     = CHAR_W'(48);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_SIZE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic rem;
        logic size;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic digits_done;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/sdaf_ctrl.sv =====
// Sequencing state machine: accept, digit loop, sizing, character emission.
`timescale 1ns / 1ps

module sdaf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sdaf_pkg::status_t status,
    output sdaf_pkg::cmd_t    cmd
);

    sdaf_pkg::state_t state_reg;
    sdaf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdaf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdaf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sdaf_pkg::S_MUL;
                end
            end
            sdaf_pkg::S_MUL:
            begin
                state_next = sdaf_pkg::S_REM;
            end
            sdaf_pkg::S_REM:
            begin
                state_next = status.digits_done ? sdaf_pkg::S_SIZE : sdaf_pkg::S_MUL;
            end
            sdaf_pkg::S_SIZE:
            begin
                state_next = sdaf_pkg::S_EMIT;
            end
            sdaf_pkg::S_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = sdaf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sdaf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sdaf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            sdaf_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            sdaf_pkg::S_REM:
            begin
                cmd.rem = 1'b1;
            end
            sdaf_pkg::S_SIZE:
            begin
                cmd.size = 1'b1;
            end
            sdaf_pkg::S_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // transaction accepted always starts the digit loop
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == sdaf_pkg::S_MUL))
        else $error("accepted transaction did not start digit loop");

endmodule

// ===== rtl/sdaf_dp.sv =====
// Datapath: divide-by-ten digit unit, digit store, sizing and output register.
`timescale 1ns / 1ps

module sdaf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] value,
    input  logic [sdaf_pkg::FIELD_W-1:0]        field_width,
    input  sdaf_pkg::cmd_t                      cmd,
    output sdaf_pkg::status_t                   status,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [sdaf_pkg::CHAR_W-1:0]         character,
    output logic                               last
);

    logic [sdaf_pkg::VALUE_W-1:0]   mag_reg;
    logic                           neg_reg;
    logic [sdaf_pkg::CNT_W-1:0]     width_reg;
    logic [sdaf_pkg::QUOT_W-1:0]    quot_reg;
    logic [3:0]                     digit_store [sdaf_pkg::DIGITS];
    logic [sdaf_pkg::DIG_IDX_W:0]   count_reg;
    logic [sdaf_pkg::CNT_W-1:0]     total_reg;
    logic [sdaf_pkg::CNT_W-1:0]     pad_reg;
    logic [sdaf_pkg::CNT_W-1:0]     pos_reg;
    logic                           out_valid_reg;
    logic [sdaf_pkg::CHAR_W-1:0]    char_reg;
    logic                           last_reg;

    logic [2*sdaf_pkg::VALUE_W-1:0] product;
    logic [3:0]                     rem_digit;
    logic [3:0]                     quot_x10_lo;
    logic                           width_sat;
    logic [sdaf_pkg::CNT_W-1:0]     width_next;
    logic [sdaf_pkg::CNT_W-1:0]     text_len;
    logic [sdaf_pkg::CNT_W-1:0]     total_next;
    logic [sdaf_pkg::CNT_W-1:0]     digit_pos;

    assign product     = (2*sdaf_pkg::VALUE_W)'(mag_reg)
                       * (2*sdaf_pkg::VALUE_W)'(sdaf_pkg::RECIP_TEN);
    assign quot_x10_lo = {quot_reg[0], 3'b000} + {quot_reg[2:0], 1'b0};
    assign rem_digit   = mag_reg[3:0] - quot_x10_lo;

    assign width_sat  = {1'b0, field_width} > 7'(sdaf_pkg::MAX_FIELD_WIDTH);
    assign width_next = width_sat ? sdaf_pkg::CNT_W'(sdaf_pkg::MAX_FIELD_WIDTH)
                                  : sdaf_pkg::CNT_W'(field_width);

    assign text_len   = sdaf_pkg::CNT_W'(count_reg) + sdaf_pkg::CNT_W'(neg_reg);
    assign total_next = (width_reg > text_len) ? width_reg : text_len;

    assign digit_pos = total_reg - pos_reg - sdaf_pkg::CNT_W'(1);

    assign status.digits_done = (quot_reg == '0)
                              || (count_reg == (sdaf_pkg::DIG_IDX_W+1)'(sdaf_pkg::DIGITS - 1));
    assign status.emit_last   = (pos_reg == total_reg - sdaf_pkg::CNT_W'(1));
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (cmd.rem)
            begin
                count_reg <= count_reg + (sdaf_pkg::DIG_IDX_W+1)'(1);
            end

            if (cmd.size)
            begin
                pos_reg <= '0;
            end
            else if (cmd.emit)
            begin
                pos_reg <= pos_reg + sdaf_pkg::CNT_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg   <= value[sdaf_pkg::VALUE_W-1];
            mag_reg   <= value[sdaf_pkg::VALUE_W-1] ? (~value + sdaf_pkg::VALUE_W'(1)) : value;
            width_reg <= width_next;
        end
        else if (cmd.rem)
        begin
            mag_reg <= sdaf_pkg::VALUE_W'(quot_reg);
        end

        if (cmd.mul)
        begin
            quot_reg <= product[2*sdaf_pkg::VALUE_W-1 -: sdaf_pkg::QUOT_W];
        end

        if (cmd.rem)
        begin
            digit_store[count_reg[sdaf_pkg::DIG_IDX_W-1:0]] <= rem_digit;
        end

        if (cmd.size)
        begin
            total_reg <= total_next;
            pad_reg   <= total_next - text_len;
        end

        if (cmd.emit)
        begin
            last_reg <= status.emit_last;
            if (pos_reg < pad_reg)
            begin
                char_reg <= sdaf_pkg::CH_BLANK;
            end
            else if ((pos_reg == pad_reg) && neg_reg)
            begin
                char_reg <= sdaf_pkg::CH_MINUS;
            end
            else
            begin
                char_reg <= sdaf_pkg::CH_ZERO
                          + {2'b00, digit_store[digit_pos[sdaf_pkg::DIG_IDX_W-1:0]]};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (pos_reg < total_reg))
        else $error("character emitted beyond text length");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem |-> (count_reg < (sdaf_pkg::DIG_IDX_W+1)'(sdaf_pkg::DIGITS)))
        else $error("digit store overflow");

    a_size_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.size |-> (count_reg != '0))
        else $error("sizing with no digits");

    a_digit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem |-> (rem_digit < 4'd10))
        else $error("remainder out of decimal range");

endmodule

// ===== rtl/signed_decimal_ascii_formatter_core.sv =====
// Sequence: each of the D digits (D = 1..10) gets a multiply step, then a remainder step, in the
// shared divide-by-ten unit; a sizing step follows, then N = max(field width capped at 32, text
// length) characters, one per cycle unless output stalls; input stalls until the last is emitted.
// Reset: field_width returns to 8, controller idles ready for input, output valid is cleared.
// Top level of the signed decimal ASCII formatter.
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sdaf_pkg::FIELD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sdaf_pkg::CHAR_W-1:0]         character,
    output logic                               last
);

    logic [sdaf_pkg::FIELD_W-1:0] field_width_reg;
    sdaf_pkg::cmd_t               cmd;
    sdaf_pkg::status_t            status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= sdaf_pkg::WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            field_width_reg <= cfg_data;
        end
    end

    sdaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sdaf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .field_width (field_width_reg),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .character   (character),
        .last        (last)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the signed decimal ASCII formatter core.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int PHASES = 8;

    typedef struct packed {
        logic [sdaf_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    class text_checker;
        logic [sdaf_pkg::FIELD_W-1:0] width;
        text_char_t pending[$];
        int errors;
        int values;
        int chars;

        function new();
            width = sdaf_pkg::WIDTH_RESET;
            errors = 0;
            values = 0;
            chars = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Expand one accepted integer into its padded decimal text
        function void add_value(logic signed [sdaf_pkg::VALUE_W-1:0] v);
            logic [31:0] mag;
            logic [3:0]  digs [10];
            int          n;
            int          text_len;
            int          w;
            int          total;
            bit          neg;
            text_char_t  c;
            neg = v[31];
            mag = neg ? (~v + 32'd1) : v;
            n = 0;
            do
            begin
                digs[n] = 4'(mag % 10);
                n++;
                mag = mag / 10;
            end
            while (mag != 0 && n < 10);
            text_len = n + (neg ? 1 : 0);
            w = (width > sdaf_pkg::MAX_FIELD_WIDTH) ? sdaf_pkg::MAX_FIELD_WIDTH : int'(width);
            total = (w > text_len) ? w : text_len;
            for (int i = 0; i < total - text_len; i++)
            begin
                c.ch = sdaf_pkg::CH_BLANK;
                c.last = 1'b0;
                pending.push_back(c);
            end
            if (neg)
            begin
                c.ch = sdaf_pkg::CH_MINUS;
                c.last = 1'b0;
                pending.push_back(c);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                c.ch = sdaf_pkg::CH_ZERO + sdaf_pkg::CHAR_W'(digs[i]);
                c.last = (i == 0);
                pending.push_back(c);
            end
            values++;
        endfunction

        task check_char(logic [sdaf_pkg::CHAR_W-1:0] ch, logic lst);
            text_char_t e;
            chars++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected character %0d last %0b", ch, lst));
            end
            else
            begin
                e = pending.pop_front();
                if (ch !== e.ch)
                    report($sformatf("character %0d, expected %0d", ch, e.ch));
                if (lst !== e.last)
                    report($sformatf("last %0b, expected %0b", lst, e.last));
            end
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [sdaf_pkg::FIELD_W-1:0]       cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic signed [sdaf_pkg::VALUE_W-1:0] value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [sdaf_pkg::CHAR_W-1:0]        character;
    logic                               last;

    text_checker sb = new();
    int  in_idle_pct = 0;
    int  out_stall_pct = 0;
    int  cycles = 0;
    int  cfg_writes = 0;

    signed_decimal_ascii_formatter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= (out_stall_pct > 0) && ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.add_value(value);
            if (cfg_valid && cfg_ready)
            begin
                sb.width = cfg_data;
                cfg_writes++;
            end
            if (out_valid && !out_stall)
                sb.check_char(character, last);
        end
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task send_value(logic signed [sdaf_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < in_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task write_width(logic [sdaf_pkg::FIELD_W-1:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     k;
        logic signed [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1:
            begin
                k = $urandom_range(1, 10);
                lo = (k == 1) ? 0 : 64'd1;
                hi = 1;
                for (int i = 0; i < k; i++)
                    hi = hi * 10;
                if (k > 1)
                    lo = hi / 10;
                hi = hi - 1;
                if (hi > 64'd2147483647)
                    hi = 64'd2147483647;
                mag = lo + (longint'($urandom) % (hi - lo + 1));
                v = 32'(mag);
                if ($urandom_range(1))
                    v = -v;
            end
            2: v = $urandom_range(1) ? 32'($urandom_range(99)) : -32'($urandom_range(99));
            default: v = $urandom_range(1) ? 32'h7FFF_FFFF - 32'($urandom_range(15))
                                           : 32'h8000_0000 + 32'($urandom_range(15));
        endcase
        return v;
    endfunction

    logic signed [31:0] directed [] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99999,
        32'sd2147483647, 32'h8000_0000, 32'sd1000000000, -32'sd999999999,
        32'h5555_5555, 32'hAAAA_AAAA, 32'sd12345678, -32'sd1234567, 32'sd100
    };

    logic [sdaf_pkg::FIELD_W-1:0] widths [PHASES] = '{
        6'd0, 6'd63, 6'd32, 6'd1, 6'd33, 6'd11, 6'd12, 6'd0
    };

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_value(directed[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_width((p == PHASES - 1) ? 6'($urandom_range(63)) : widths[p]);
            case (p % 4)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct = 45;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 45;
                end
                default:
                begin
                    in_idle_pct = 30;
                    out_stall_pct = 30;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_value(pick_value());
            drain();
        end

        repeat (60) @(posedge clk);
        $display("Converted %0d values into %0d characters over %0d field width settings,",
                 sb.values, sb.chars, cfg_writes + 1);
        $display("with input gaps and output stalls mixed in across phases.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
